[rtl/tbsa_pkg.sv]
// Shared types, sizes and helper functions of the two-level bitmap slot allocator.
// Depends on nothing; every other file of the allocator imports it.
package tbsa_pkg;

    // Geometry of the pool frame.
    localparam int CELL_BITS   = 32;
    localparam int CELL_COUNT  = 8;
    localparam int SLOT_TOTAL  = CELL_BITS * CELL_COUNT;
    localparam int CELL_IDX_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int BIT_IDX_W   = $clog2(CELL_BITS);
    localparam int SLOT_W      = $clog2(SLOT_TOTAL + 1);

    // Field and register widths fixed by the interface.
    localparam int INDEX_W        = 8;
    localparam int OFFSET_W       = 20;
    localparam int SLOT_COUNT_W   = 9;
    localparam int ENTITY_SIZE_W  = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_ADDR_W     = 1;
    localparam int CMP_W          = (SLOT_W > SLOT_COUNT_W) ? SLOT_W : SLOT_COUNT_W;

    localparam logic [SLOT_COUNT_W-1:0]  SLOT_COUNT_RESET  = 9'd256;
    localparam logic [ENTITY_SIZE_W-1:0] ENTITY_SIZE_RESET = 13'd16;

    typedef logic [CELL_BITS-1:0]  cell_word_t;
    typedef logic [CELL_COUNT-1:0] summary_t;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_RELEASE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_GRANTED     = 2'd0,
        STATUS_FULL        = 2'd1,
        STATUS_RELEASED    = 2'd2,
        STATUS_RANGE_ERROR = 2'd3
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SLOT_COUNT  = 1'b0,
        REG_ENTITY_SIZE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [SLOT_COUNT_W-1:0]  slot_count;
        logic [ENTITY_SIZE_W-1:0] entity_size;
    } cfg_t;

    typedef struct packed {
        op_t                operation;
        logic [INDEX_W-1:0] slot_index;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] granted_index;
    } decision_t;

    // Priority encoders: index of the lowest set bit, zero for an empty word.
    function automatic logic [CELL_IDX_W-1:0] lowest_cell(input summary_t w);
        logic [CELL_IDX_W-1:0] idx;
        idx = '0;
        for (int i = CELL_COUNT - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = CELL_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lowest_bit(input cell_word_t w);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = CELL_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/tbsa_cfg.sv]
// Configuration registers of the slot allocator: slot count and entity size.
// Depends on tbsa_pkg.
module tbsa_cfg
    import tbsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [SLOT_COUNT_W-1:0]  slot_count_reg;
    logic [ENTITY_SIZE_W-1:0] entity_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg  <= SLOT_COUNT_RESET;
            entity_size_reg <= ENTITY_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_addr))
                REG_SLOT_COUNT:  slot_count_reg  <= cfg_wdata[SLOT_COUNT_W-1:0];
                REG_ENTITY_SIZE: entity_size_reg <= cfg_wdata[ENTITY_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.slot_count  = slot_count_reg;
    assign cfg.entity_size = entity_size_reg;

endmodule

[rtl/tbsa_bitmap.sv]
// Free bitmap and cell summary of the allocator, with the allocate and release decision.
// Depends on tbsa_pkg.
module tbsa_bitmap
    import tbsa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    apply,
    input  request_t                req,
    input  logic [SLOT_COUNT_W-1:0] slot_count,
    output decision_t               decision
);

    cell_word_t cells_reg [CELL_COUNT];
    cell_word_t cells_next [CELL_COUNT];
    summary_t   summary_reg;
    summary_t   summary_next;

    logic [CELL_IDX_W-1:0] alloc_cell;
    logic [BIT_IDX_W-1:0]  alloc_bit;
    cell_word_t            alloc_word;
    logic [SLOT_W-1:0]     alloc_slot;
    logic                  alloc_ok;

    logic [SLOT_W-1:0]     rel_slot;
    logic [CELL_IDX_W-1:0] rel_cell;
    logic [BIT_IDX_W-1:0]  rel_bit;
    logic                  rel_ok;

    // Allocate: lowest cell with free slots, then lowest free slot in it.
    assign alloc_cell = lowest_cell(summary_reg);
    assign alloc_word = cells_reg[alloc_cell];
    assign alloc_bit  = lowest_bit(alloc_word);
    assign alloc_slot = SLOT_W'(CELL_BITS) * SLOT_W'(alloc_cell) + SLOT_W'(alloc_bit);
    assign alloc_ok   = (|summary_reg) && (|alloc_word)
                        && (CMP_W'(alloc_slot) < CMP_W'(slot_count))
                        && (CMP_W'(alloc_slot) < CMP_W'(SLOT_TOTAL));

    // Release: the index must lie below both the slot count and the frame size.
    assign rel_slot = SLOT_W'(req.slot_index);
    assign rel_cell = CELL_IDX_W'(rel_slot / CELL_BITS);
    assign rel_bit  = BIT_IDX_W'(rel_slot % CELL_BITS);
    assign rel_ok   = (CMP_W'(req.slot_index) < CMP_W'(slot_count))
                      && (CMP_W'(req.slot_index) < CMP_W'(SLOT_TOTAL));

    always_comb begin
        decision.granted_index = '0;
        if (req.operation == OP_ALLOCATE) begin
            if (alloc_ok) begin
                decision.status        = STATUS_GRANTED;
                decision.granted_index = alloc_slot[INDEX_W-1:0];
            end else begin
                decision.status = STATUS_FULL;
            end
        end else begin
            decision.status = rel_ok ? STATUS_RELEASED : STATUS_RANGE_ERROR;
        end
    end

    always_comb begin
        for (int c = 0; c < CELL_COUNT; c++) begin
            cells_next[c] = cells_reg[c];
        end
        summary_next = summary_reg;
        if (apply) begin
            if (req.operation == OP_ALLOCATE) begin
                if (alloc_ok) begin
                    cells_next[alloc_cell][alloc_bit] = 1'b0;
                    if (cells_next[alloc_cell] == '0) begin
                        summary_next[alloc_cell] = 1'b0;
                    end
                end
            end else if (rel_ok) begin
                cells_next[rel_cell][rel_bit] = 1'b1;
                summary_next[rel_cell]        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CELL_COUNT; c++) begin
                cells_reg[c] <= '1;
            end
            summary_reg <= '1;
        end else begin
            for (int c = 0; c < CELL_COUNT; c++) begin
                cells_reg[c] <= cells_next[c];
            end
            summary_reg <= summary_next;
        end
    end

endmodule

[rtl/two_level_bitmap_slot_allocator_core.sv]
// Top level of the two-level bitmap slot allocator: input register, result register, offset.
// Depends on tbsa_pkg, tbsa_cfg and tbsa_bitmap.
//
// Usage
// The slave channel takes one request word per handshake: tuser carries the operation
// (allocate or release) and tdata the slot index to release, which allocates ignore.
// The master channel returns exactly one result word per request, in order: tuser holds
// the status and tdata the granted slot index and its byte offset, both zero unless a
// slot was granted.
// A request is captured in an input register; when it advances, the bitmap lookup, the
// bitmap update and the offset multiplication complete together into the result
// register, from which its result is offered on the master channel. A new request can
// be taken in every cycle while the receiver does not stall; the bitmap state updates at
// the same edge as the result register, so each request sees all earlier ones. One word
// per cycle is limited by that single lookup-and-update path through the bitmap.
// If the receiver stalls, a finished result waits in the result register and one more
// request is still taken into the input register before s_tready falls.
// Reset marks every slot free, sets the slot count to 256 and the entity size to 16,
// and empties both registers. Configuration writes are meant for idle periods only.
module two_level_bitmap_slot_allocator_core
    import tbsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] slot_index
    input  logic [0:0]            s_tuser,   // [0] operation

    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [7:0] granted_index, [27:8] byte_offset, zeros
    output logic [1:0]            m_tuser,   // [1:0] status

    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg;
    decision_t decision;
    request_t  req;
    logic      advance;

    // Input register.
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [INDEX_W-1:0] in_index_reg;

    // Result register.
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    logic [INDEX_W+ENTITY_SIZE_W-1:0] offset_full;

    // The held request moves on whenever the result register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign req.operation  = in_op_reg;
    assign req.slot_index = in_index_reg;

    tbsa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbsa_bitmap u_bitmap (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .apply      (advance),
        .req        (req),
        .slot_count (cfg.slot_count),
        .decision   (decision)
    );

    // The granted index is zero for every other outcome, so the offset is zero as well.
    assign offset_full = (INDEX_W+ENTITY_SIZE_W)'(decision.granted_index)
                         * (INDEX_W+ENTITY_SIZE_W)'(cfg.entity_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg    <= op_t'(s_tuser[0]);
            in_index_reg <= s_tdata[INDEX_W-1:0];
        end
        if (advance) begin
            out_status_reg <= decision.status;
            out_index_reg  <= decision.granted_index;
            out_offset_reg <= offset_full[OFFSET_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_offset_reg, out_index_reg};

endmodule

[rtl/tbsa_checker.sv]
// Port-level checker for the slot allocator top level, attached with a bind statement.
// Depends on tbsa_pkg and two_level_bitmap_slot_allocator_core.
module tbsa_checker
    import tbsa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Nothing is offered on the result channel straight after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // The request side only stalls while a result waits unread.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request channel stalled without a waiting result");

    // Every outcome other than a grant carries a zero index and offset.
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_GRANTED)) |-> (m_tdata == 32'd0))
        else $error("non-grant result with non-zero payload");

    // A stalled result stays offered and unchanged.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind two_level_bitmap_slot_allocator_core tbsa_checker u_tbsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
